### rtl/core/wgo_pkg.sv
// Shared types and constants for the wall grid occupancy test.
// Holds op codes, direction codes, register indexes, FSM state and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package wgo_pkg;

	// Request op codes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Wall direction codes
	localparam logic [1:0] DIR_HORZ = 2'd0;
	localparam logic [1:0] DIR_VERT = 2'd1;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;     // request taken this cycle
		logic post_imm;   // write the immediate result of the request
		logic scan_start; // latch query cell, reset address and hit flag
		logic rd_en;      // read one table entry, advance address
		logic post_scan;  // write the result of the finished scan
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic full;     // table holds the maximum number of walls
		logic empty;    // table holds no wall
		logic outside;  // incoming query cell lies outside the grid
		logic last_rd;  // current read address is the last stored wall
		logic out_free; // output register can take a result this cycle
	} dp_stat_t;

endpackage

### rtl/core/wgo_ctrl.sv
// Controller state machine for the wall grid occupancy test.
// Sequences accept, table scan and result posting; depends on wgo_pkg.
`timescale 1ns / 1ps

module wgo_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  wgo_pkg::dp_stat_t  stat,
	output wgo_pkg::ctrl_cmd_t cmd
);

	wgo_pkg::state_t state_q;
	wgo_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wgo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		logic go_scan;
		state_d        = state_q;
		cmd            = '0;
		in_ready       = 1'b0;
		go_scan        = (op == wgo_pkg::OP_QUERY) && !stat.outside && !stat.empty;
		case (state_q)
			wgo_pkg::ST_IDLE: begin
				in_ready   = stat.out_free;
				cmd.accept = in_valid && stat.out_free;
				if (cmd.accept) begin
					if (go_scan) begin
						cmd.scan_start = 1'b1;
						state_d        = wgo_pkg::ST_SCAN;
					end else begin
						cmd.post_imm = 1'b1;
					end
				end
			end
			wgo_pkg::ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (stat.last_rd) begin
					state_d = wgo_pkg::ST_FLUSH;
				end
			end
			wgo_pkg::ST_FLUSH: begin
				// hold the last compare until the output register frees up
				if (stat.out_free) begin
					cmd.post_scan = 1'b1;
					state_d       = wgo_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wgo_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/wgo_dp.sv
// Datapath for the wall grid occupancy test: wall table memory, wall count,
// grid size registers, span compare and output register. Depends on wgo_pkg.
`timescale 1ns / 1ps

module wgo_dp #(
	parameter int unsigned MAX_WALLS  = 64,
	parameter int unsigned COORD_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [wgo_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [COORD_BITS:0]               cfg_data,
	input  logic [1:0]                        op,
	input  logic [COORD_BITS-1:0]             wall_x,
	input  logic [COORD_BITS-1:0]             wall_y,
	input  logic [COORD_BITS-1:0]             wall_length,
	input  logic [1:0]                        wall_direction,
	input  logic [COORD_BITS-1:0]             cell_x,
	input  logic [COORD_BITS-1:0]             cell_y,
	input  wgo_pkg::ctrl_cmd_t                cmd,
	output wgo_pkg::dp_stat_t                 stat,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              blocked,
	output logic                              out_of_grid,
	output logic                              rejected
);

	localparam int unsigned AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
	localparam int unsigned CW = $clog2(MAX_WALLS + 1);
	localparam int unsigned EW = 3 * COORD_BITS + 2;
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_WALLS);

	// Table entry: {direction, length, y, x}
	logic [EW-1:0]         mem [MAX_WALLS];
	logic [EW-1:0]         rd_data_s1;
	logic                  rd_vld_s1;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         addr_q;
	logic [COORD_BITS:0]   grid_w_q;
	logic [COORD_BITS:0]   grid_h_q;
	logic [COORD_BITS-1:0] cx_q;
	logic [COORD_BITS-1:0] cy_q;
	logic                  hit_q;
	logic                  out_valid_q;
	logic                  blocked_q;
	logic                  oog_q;
	logic                  rej_q;

	logic [COORD_BITS-1:0] e_x;
	logic [COORD_BITS-1:0] e_y;
	logic [COORD_BITS-1:0] e_len;
	logic [1:0]            e_dir;
	logic [COORD_BITS:0]   x_end;
	logic [COORD_BITS:0]   y_end;
	logic                  match;
	logic                  is_load;
	logic                  is_query;
	logic                  is_clear;

	assign is_load  = (op == wgo_pkg::OP_LOAD);
	assign is_query = (op == wgo_pkg::OP_QUERY);
	assign is_clear = (op == wgo_pkg::OP_CLEAR);

	// Status toward the controller
	assign stat.full     = (count_q == COUNT_MAX);
	assign stat.empty    = (count_q == '0);
	assign stat.outside  = ({1'b0, cell_x} >= grid_w_q) || ({1'b0, cell_y} >= grid_h_q);
	assign stat.last_rd  = (addr_q == AW'(count_q - 1'b1));
	assign stat.out_free = !out_valid_q || out_ready;

	// Grid size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= (COORD_BITS + 1)'(1 << COORD_BITS);
			grid_h_q <= (COORD_BITS + 1)'(1 << COORD_BITS);
		end else if (cfg_valid) begin
			if (cfg_index == wgo_pkg::REG_GRID_WIDTH) begin
				grid_w_q <= cfg_data;
			end else if (cfg_index == wgo_pkg::REG_GRID_HEIGHT) begin
				grid_h_q <= cfg_data;
			end
		end
	end

	// Wall count: advance on load, drop to zero on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.accept) begin
			if (is_load && !stat.full) begin
				count_q <= count_q + 1'b1;
			end else if (is_clear) begin
				count_q <= '0;
			end
		end
	end

	// Table write
	always_ff @(posedge clk) begin
		if (cmd.accept && is_load && !stat.full) begin
			mem[count_q[AW-1:0]] <= {wall_direction, wall_length, wall_y, wall_x};
		end
	end

	// Table read, registered
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[addr_q];
		end
	end

	// Scan address and query cell
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			cx_q   <= cell_x;
			cy_q   <= cell_y;
			addr_q <= '0;
		end else if (cmd.rd_en) begin
			addr_q <= addr_q + 1'b1;
		end
	end

	// Span compare on the entry read last cycle
	assign e_x   = rd_data_s1[COORD_BITS-1:0];
	assign e_y   = rd_data_s1[2*COORD_BITS-1:COORD_BITS];
	assign e_len = rd_data_s1[3*COORD_BITS-1:2*COORD_BITS];
	assign e_dir = rd_data_s1[EW-1:3*COORD_BITS];
	assign x_end = {1'b0, e_x} + {1'b0, e_len};
	assign y_end = {1'b0, e_y} + {1'b0, e_len};

	always_comb begin
		match = 1'b0;
		if (e_dir == wgo_pkg::DIR_HORZ) begin
			match = (cy_q == e_y) && (cx_q >= e_x) && ({1'b0, cx_q} < x_end);
		end else if (e_dir == wgo_pkg::DIR_VERT) begin
			match = (cx_q == e_x) && (cy_q >= e_y) && ({1'b0, cy_q} < y_end);
		end
	end

	// Read-valid flag and hit accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.scan_start) begin
				hit_q <= 1'b0;
			end else if (rd_vld_s1 && match) begin
				hit_q <= 1'b1;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.post_imm || cmd.post_scan) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.post_imm) begin
			blocked_q <= 1'b0;
			oog_q     <= is_query && stat.outside;
			rej_q     <= is_load && stat.full;
		end else if (cmd.post_scan) begin
			blocked_q <= hit_q || (rd_vld_s1 && match);
			oog_q     <= 1'b0;
			rej_q     <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign blocked     = blocked_q;
	assign out_of_grid = oog_q;
	assign rejected    = rej_q;

endmodule

### rtl/core/wall_grid_occupancy_test.sv
// Wall grid occupancy test: load, clear and query of axis-aligned walls.
// Load, clear, unused op and outside or empty-table queries give their result in
// the output register in the cycle after the request is taken; other queries read
// the stored walls from the table memory, one per cycle, then wait in a flush state
// until the output register is free; no new request is taken meanwhile. Reset clears
// the wall count and sets both grid sizes to 2**COORD_BITS; the table is not cleared.
`timescale 1ns / 1ps

module wall_grid_occupancy_test #(
	parameter int unsigned MAX_WALLS  = 64,
	parameter int unsigned COORD_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wgo_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS:0]              cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       op,
	input  logic [COORD_BITS-1:0]            wall_x,
	input  logic [COORD_BITS-1:0]            wall_y,
	input  logic [COORD_BITS-1:0]            wall_length,
	input  logic [1:0]                       wall_direction,
	input  logic [COORD_BITS-1:0]            cell_x,
	input  logic [COORD_BITS-1:0]            cell_y,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             blocked,
	output logic                             out_of_grid,
	output logic                             rejected
);

	wgo_pkg::ctrl_cmd_t cmd;
	wgo_pkg::dp_stat_t  stat;

	// Register writes are always taken
	assign cfg_ready = 1'b1;

	wgo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.stat     (stat),
		.cmd      (cmd)
	);

	wgo_dp #(
		.MAX_WALLS  (MAX_WALLS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.op             (op),
		.wall_x         (wall_x),
		.wall_y         (wall_y),
		.wall_length    (wall_length),
		.wall_direction (wall_direction),
		.cell_x         (cell_x),
		.cell_y         (cell_y),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.blocked        (blocked),
		.out_of_grid    (out_of_grid),
		.rejected       (rejected)
	);

endmodule

### test/wgo_checker.sv
// Checker for the wall grid occupancy test: watches the config, request and result channels.
// Keeps its own wall list and grid sizes, predicts each result and compares it field by field.
// Depends on wgo_pkg for op, direction and register codes.
`timescale 1ns / 1ps

module wgo_checker #(
	parameter int unsigned MAX_WALLS  = 64,
	parameter int unsigned COORD_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [wgo_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS:0]              cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  logic [1:0]                       op,
	input  logic [COORD_BITS-1:0]            wall_x,
	input  logic [COORD_BITS-1:0]            wall_y,
	input  logic [COORD_BITS-1:0]            wall_length,
	input  logic [1:0]                       wall_direction,
	input  logic [COORD_BITS-1:0]            cell_x,
	input  logic [COORD_BITS-1:0]            cell_y,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic                             blocked,
	input  logic                             out_of_grid,
	input  logic                             rejected,
	output int                               outstanding,
	output int                               mismatches
);

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] len;
		logic [1:0]            dir;
	} wall_seg_t;

	typedef struct packed {
		logic blocked;
		logic out_of_grid;
		logic rejected;
	} cell_flags_t;

	wall_seg_t           wall_list [MAX_WALLS];
	int unsigned         walls_held;
	logic [COORD_BITS:0] grid_cols;
	logic [COORD_BITS:0] grid_rows;
	cell_flags_t         expected_flags_q [$];

	// Spans are taken at full integer width, so a long wall never wraps
	function automatic bit covers_cell(wall_seg_t w, int unsigned cx, int unsigned cy);
		int unsigned sx, sy, span;
		sx   = 32'(w.x);
		sy   = 32'(w.y);
		span = 32'(w.len);
		if (w.dir == wgo_pkg::DIR_HORZ)
			return cy == sy && cx >= sx && cx < sx + span;
		if (w.dir == wgo_pkg::DIR_VERT)
			return cx == sx && cy >= sy && cy < sy + span;
		return 1'b0;
	endfunction

	// Update the wall list for one request and work out its result
	function automatic cell_flags_t apply_request(logic [1:0] req_op, wall_seg_t seg,
			int unsigned cx, int unsigned cy);
		cell_flags_t r;
		r = '0;
		case (req_op)
			wgo_pkg::OP_LOAD: begin
				if (walls_held >= MAX_WALLS) begin
					r.rejected = 1'b1;
				end else begin
					wall_list[walls_held] = seg;
					walls_held++;
				end
			end
			wgo_pkg::OP_QUERY: begin
				if (cx >= grid_cols || cy >= grid_rows) begin
					r.out_of_grid = 1'b1;
				end else begin
					for (int i = 0; i < walls_held; i++)
						if (covers_cell(wall_list[i], cx, cy))
							r.blocked = 1'b1;
				end
			end
			wgo_pkg::OP_CLEAR: begin
				walls_held = 0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_error(string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Check results first, then take config writes and new requests of the same edge
	always @(posedge clk or negedge arst_n) begin
		cell_flags_t want;
		wall_seg_t seg;
		if (!arst_n) begin
			walls_held = 0;
			grid_cols  = (COORD_BITS + 1)'(1 << COORD_BITS);
			grid_rows  = (COORD_BITS + 1)'(1 << COORD_BITS);
			mismatches = 0;
			expected_flags_q.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_flags_q.size() == 0) begin
					report_error($sformatf(
						"unexpected result: blocked %0b out_of_grid %0b rejected %0b",
						blocked, out_of_grid, rejected));
				end else begin
					want = expected_flags_q.pop_front();
					if (blocked !== want.blocked)
						report_error($sformatf("blocked is %0b, want %0b", blocked, want.blocked));
					if (out_of_grid !== want.out_of_grid)
						report_error($sformatf("out_of_grid is %0b, want %0b",
							out_of_grid, want.out_of_grid));
					if (rejected !== want.rejected)
						report_error($sformatf("rejected is %0b, want %0b", rejected, want.rejected));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == wgo_pkg::REG_GRID_WIDTH)
					grid_cols = cfg_data;
				else if (cfg_index == wgo_pkg::REG_GRID_HEIGHT)
					grid_rows = cfg_data;
			end
			if (in_valid && in_ready) begin
				seg = '{x: wall_x, y: wall_y, len: wall_length, dir: wall_direction};
				expected_flags_q.push_back(apply_request(op, seg, 32'(cell_x), 32'(cell_y)));
			end
			outstanding <= expected_flags_q.size();
		end
	end

endmodule

### test/tb_top.sv
// Testbench top for the wall grid occupancy test: clock, reset, stimulus and verdict.
// Drives wall_grid_occupancy_test and hands every channel to wgo_checker.
// Depends on wgo_pkg, wall_grid_occupancy_test and wgo_checker.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned MAX_WALLS  = 64;
	localparam int unsigned COORD_BITS = 8;
	localparam int unsigned GRID_FULL  = 1 << COORD_BITS;
	localparam int unsigned PHASES     = 8;
	localparam int unsigned PHASE_REQS = 110;
	localparam logic [wgo_pkg::CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [wgo_pkg::CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] len;
		logic [1:0]            dir;
	} placed_wall_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [wgo_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [COORD_BITS:0]              cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic [1:0]                       op = '0;
	logic [COORD_BITS-1:0]            wall_x = '0;
	logic [COORD_BITS-1:0]            wall_y = '0;
	logic [COORD_BITS-1:0]            wall_length = '0;
	logic [1:0]                       wall_direction = '0;
	logic [COORD_BITS-1:0]            cell_x = '0;
	logic [COORD_BITS-1:0]            cell_y = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic                             blocked;
	logic                             out_of_grid;
	logic                             rejected;
	int                               outstanding;
	int                               mismatches;

	// Stimulus hints only: where walls were placed and how big the grid is
	placed_wall_t placed_walls [$];
	int unsigned  cur_cols = GRID_FULL;
	int unsigned  cur_rows = GRID_FULL;
	int           calm_left = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	wall_grid_occupancy_test #(
		.MAX_WALLS (MAX_WALLS),
		.COORD_BITS(COORD_BITS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.wall_x        (wall_x),
		.wall_y        (wall_y),
		.wall_length   (wall_length),
		.wall_direction(wall_direction),
		.cell_x        (cell_x),
		.cell_y        (cell_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.blocked       (blocked),
		.out_of_grid   (out_of_grid),
		.rejected      (rejected)
	);

	wgo_checker #(
		.MAX_WALLS (MAX_WALLS),
		.COORD_BITS(COORD_BITS)
	) occupancy_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.wall_x        (wall_x),
		.wall_y        (wall_y),
		.wall_length   (wall_length),
		.wall_direction(wall_direction),
		.cell_x        (cell_x),
		.cell_y        (cell_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.blocked       (blocked),
		.out_of_grid   (out_of_grid),
		.rejected      (rejected),
		.outstanding   (outstanding),
		.mismatches    (mismatches)
	);

	// Mostly no gap, sometimes a short one, rarely a long one; calm stretches have none
	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			calm_left = $urandom_range(10, 40);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Mostly inside the configured span, otherwise anywhere
	function automatic logic [COORD_BITS-1:0] pick_coord(int unsigned span);
		if (span == 0 || span > GRID_FULL || $urandom_range(0, 3) == 0)
			return COORD_BITS'($urandom);
		return COORD_BITS'($urandom_range(0, span - 1));
	endfunction

	// Hold the request until it is taken; leave valid high for a back-to-back follower
	task automatic send_request(logic [1:0] req_op, logic [COORD_BITS-1:0] wx,
			logic [COORD_BITS-1:0] wy, logic [COORD_BITS-1:0] wl, logic [1:0] wd,
			logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		op             <= req_op;
		wall_x         <= wx;
		wall_y         <= wy;
		wall_length    <= wl;
		wall_direction <= wd;
		cell_x         <= cx;
		cell_y         <= cy;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending and wait until every expected result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Valid stays high across back-to-back writes; the caller drops it afterwards
	task automatic write_reg(logic [wgo_pkg::CFG_IDX_BITS-1:0] idx, logic [COORD_BITS:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_wall();
		placed_wall_t w;
		w.x   = pick_coord(cur_cols);
		w.y   = pick_coord(cur_rows);
		w.len = ($urandom_range(0, 3) == 0) ? COORD_BITS'($urandom)
			: COORD_BITS'($urandom_range(0, 12));
		w.dir = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
			: 2'($urandom_range(0, 1));
		send_request(wgo_pkg::OP_LOAD, w.x, w.y, w.len, w.dir,
			COORD_BITS'($urandom), COORD_BITS'($urandom));
		if (placed_walls.size() < MAX_WALLS)
			placed_walls.push_back(w);
	endtask

	// Aim most queries on or next to a placed wall
	task automatic query_cell();
		placed_wall_t w;
		int along, across;
		logic [COORD_BITS-1:0] cx, cy;
		cx = pick_coord(cur_cols);
		cy = pick_coord(cur_rows);
		if (placed_walls.size() != 0 && $urandom_range(0, 3) != 0) begin
			w      = placed_walls[$urandom_range(0, placed_walls.size() - 1)];
			along  = int'($urandom_range(0, w.len + 1)) - 1;
			across = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 1 : -1) : 0;
			if (w.dir == wgo_pkg::DIR_VERT) begin
				cx = COORD_BITS'(int'(w.x) + across);
				cy = COORD_BITS'(int'(w.y) + along);
			end else begin
				cx = COORD_BITS'(int'(w.x) + along);
				cy = COORD_BITS'(int'(w.y) + across);
			end
		end
		send_request(wgo_pkg::OP_QUERY, COORD_BITS'($urandom), COORD_BITS'($urandom),
			COORD_BITS'($urandom), 2'($urandom), cx, cy);
	endtask

	task automatic clear_walls();
		send_request(wgo_pkg::OP_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom),
			COORD_BITS'($urandom), 2'($urandom), COORD_BITS'($urandom),
			COORD_BITS'($urandom));
		placed_walls.delete();
	endtask

	// Grid sizes per phase: defaults, smallest, zero, beyond range, one narrow side and a random pick
	task automatic set_grid(int unsigned phase);
		int unsigned cols, rows;
		case (phase)
			0: begin cols = GRID_FULL; rows = GRID_FULL; end
			1: begin cols = 1;         rows = 1;         end
			2: begin cols = 0;         rows = 300;       end
			3: begin cols = 511;       rows = 0;         end
			4: begin cols = 16;        rows = GRID_FULL; end
			5: begin cols = GRID_FULL; rows = 9;         end
			6: begin cols = $urandom_range(1, GRID_FULL); rows = $urandom_range(1, GRID_FULL); end
			default: begin cols = 257; rows = 255; end
		endcase
		write_reg(wgo_pkg::REG_GRID_WIDTH, (COORD_BITS + 1)'(cols));
		write_reg(wgo_pkg::REG_GRID_HEIGHT, (COORD_BITS + 1)'(rows));
		// Spare indexes must leave both sizes alone
		if (phase == 2 || phase == 3) begin
			write_reg(REG_SPARE_A, 9'h1FF);
			write_reg(REG_SPARE_B, 9'h155);
		end
		cfg_valid <= 1'b0;
		cur_cols = cols;
		cur_rows = rows;
	endtask

	// Result side: ready bursts with short and long stalls, and some long free runs
	initial begin : result_sink
		int run, stall;
		while (!arst_n) @(posedge clk);
		forever begin
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6);
			if ($urandom_range(0, 9) == 0)
				stall = $urandom_range(10, 60);
			else
				stall = $urandom_range(0, 3);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int unsigned sent, n_load, n_query, n_noise;
		logic [1:0] rand_op;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extreme walls, odd directions, zero length, spare op, clear
		send_request(wgo_pkg::OP_QUERY, 0, 0, 0, wgo_pkg::DIR_HORZ, 0, 0);
		send_request(wgo_pkg::OP_LOAD, 0, 0, 255, wgo_pkg::DIR_HORZ, 0, 0);
		send_request(wgo_pkg::OP_LOAD, 255, 0, 255, wgo_pkg::DIR_VERT, 0, 0);
		send_request(wgo_pkg::OP_LOAD, 100, 100, 0, wgo_pkg::DIR_HORZ, 0, 0);
		send_request(wgo_pkg::OP_LOAD, 50, 50, 10, 2'd2, 0, 0);
		send_request(wgo_pkg::OP_LOAD, 60, 60, 10, 2'd3, 0, 0);
		send_request(wgo_pkg::OP_LOAD, 200, 255, 255, wgo_pkg::DIR_HORZ, 0, 0);
		send_request(wgo_pkg::OP_QUERY, 0, 0, 0, wgo_pkg::DIR_HORZ, 0, 0);
		send_request(wgo_pkg::OP_QUERY, 0, 0, 0, wgo_pkg::DIR_HORZ, 254, 0);
		send_request(wgo_pkg::OP_QUERY, 0, 0, 0, wgo_pkg::DIR_HORZ, 255, 0);
		send_request(wgo_pkg::OP_QUERY, 0, 0, 0, wgo_pkg::DIR_HORZ, 255, 254);
		send_request(wgo_pkg::OP_QUERY, 0, 0, 0, wgo_pkg::DIR_HORZ, 255, 255);
		send_request(wgo_pkg::OP_QUERY, 0, 0, 0, wgo_pkg::DIR_HORZ, 199, 255);
		send_request(wgo_pkg::OP_QUERY, 0, 0, 0, wgo_pkg::DIR_HORZ, 100, 100);
		send_request(wgo_pkg::OP_QUERY, 0, 0, 0, wgo_pkg::DIR_HORZ, 50, 50);
		send_request(wgo_pkg::OP_QUERY, 0, 0, 0, wgo_pkg::DIR_HORZ, 60, 61);
		send_request(wgo_pkg::OP_QUERY, 0, 0, 0, wgo_pkg::DIR_HORZ, 0, 1);
		send_request(OP_SPARE, 0, 0, 0, wgo_pkg::DIR_HORZ, 0, 0);
		send_request(OP_SPARE, 255, 255, 255, 2'd3, 255, 255);
		send_request(wgo_pkg::OP_QUERY, 0, 0, 0, wgo_pkg::DIR_HORZ, 0, 0);
		send_request(wgo_pkg::OP_CLEAR, 0, 0, 0, wgo_pkg::DIR_HORZ, 0, 0);
		send_request(wgo_pkg::OP_QUERY, 0, 0, 0, wgo_pkg::DIR_HORZ, 0, 0);
		send_request(wgo_pkg::OP_QUERY, 255, 255, 255, 2'd3, 255, 0);

		// Random: per grid setting, mostly clear/load/probe sequences, some noise
		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			drain_results();
			set_grid(phase);
			sent = 0;
			while (sent < PHASE_REQS) begin
				if ($urandom_range(0, 4) != 0) begin
					clear_walls();
					n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
						: $urandom_range(1, 12);
					n_query = $urandom_range(4, 20);
					repeat (n_load) load_wall();
					repeat (n_query) query_cell();
					sent += 1 + n_load + n_query;
				end else begin
					n_noise = $urandom_range(1, 8);
					repeat (n_noise) begin
						rand_op = 2'($urandom);
						send_request(rand_op, COORD_BITS'($urandom), COORD_BITS'($urandom),
							COORD_BITS'($urandom), 2'($urandom), COORD_BITS'($urandom),
							COORD_BITS'($urandom));
						if (rand_op == wgo_pkg::OP_CLEAR)
							placed_walls.delete();
						if (rand_op != OP_SPARE)
							sent++;
					end
				end
				// Hold off now and then until the block has caught up
				if ($urandom_range(0, 19) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (MAX_WALLS + 16) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS wall_grid_occupancy_test");
		else
			$display("FAIL wall_grid_occupancy_test");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("FAIL wall_grid_occupancy_test");
		$finish;
	end

endmodule
